[src/efe_pkg.sv]
// Shared types, constants and helpers for the Enge product field evaluator.
// No dependencies; used by efe_side, efe_factor and enge_product_field_eval.
package efe_pkg;

   // Fixed-point word types
   typedef logic signed [23:0] fix24_type;
   typedef logic signed [18:0] offset_type;
   typedef logic [20:0]        factor_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_ENTRY_LO  = 3'd0,
      REG_ENTRY_HI  = 3'd1,
      REG_EXIT_LO   = 3'd2,
      REG_EXIT_HI   = 3'd3,
      REG_AMPLITUDE = 3'd4,
      REG_HALF_LEN  = 3'd5,
      REG_INV_APER  = 3'd6
   } csr_index_type;

   // Register reset values
   localparam logic [16:0] HALF_LEN_RESET = 17'd45875;
   localparam logic [23:0] INV_APER_RESET = 24'd163840;

   // Saturation limit for polynomial and offset scaling (+-(2^23-1))
   localparam logic signed [47:0] SAT23 = 48'sd8388607;

   // Stage counts of the pipeline sections
   localparam int SIDE_LAT   = 13;
   localparam int FACTOR_LAT = 47;
   localparam int PIPE_LAT   = SIDE_LAT + FACTOR_LAT + 2;

   // Floor of 2^32 / k for the series divisors k = 1..6
   localparam logic [32:0] RECIP_TAB [1:6] = '{
      33'd4294967296, 33'd2147483648, 33'd1431655765,
      33'd1073741824, 33'd858993459,  33'd715827882
   };

   // Clamp a wide signed value to +-(2^23-1)
   function automatic fix24_type clamp24(input logic signed [47:0] v);
      fix24_type res;
      if (v > SAT23) begin
         res = 24'sd8388607;
      end else if (v < -SAT23) begin
         res = -24'sd8388607;
      end else begin
         res = v[23:0];
      end
      return res;
   endfunction

endpackage

[src/efe_side.sv]
// One side of the evaluator: offset scaling and fifth-order Horner polynomial.
// Depends on efe_pkg. Thirteen register stages, all advanced by en.
module efe_side (
   input  logic                clock,
   input  logic                en,
   input  efe_pkg::offset_type offset,
   input  logic [23:0]         inv_aperture,
   input  logic [63:0]         coeff_lo,
   input  logic [31:0]         coeff_hi,
   output efe_pkg::fix24_type  poly_value
);

   logic signed [18:0] d_ff;
   logic signed [43:0] sp_ff;
   logic signed [43:0] sp_in;
   efe_pkg::fix24_type s_ff;
   efe_pkg::fix24_type s_in;
   efe_pkg::fix24_type acc0;
   logic signed [15:0] c5;

   efe_pkg::fix24_type acc_ff  [1:5];
   logic signed [47:0] prod_ff [0:4];
   efe_pkg::fix24_type sm_ff   [0:4];
   efe_pkg::fix24_type sa_ff   [0:4];

   // Scale offset by 1/(2*R0), floor to Q.16 and saturate
   assign sp_in = d_ff * $signed({1'b0, inv_aperture});
   assign s_in  = efe_pkg::clamp24($signed({{4{sp_ff[43]}}, sp_ff}) >>> 16);

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff  <= offset;
         sp_ff <= sp_in;
         s_ff  <= s_in;
      end
   end

   // Seed the accumulator with c5 * 64
   assign c5   = coeff_hi[31:16];
   assign acc0 = {{2{c5[15]}}, c5, 6'b0};

   // One Horner step per multiply stage plus add stage
   for (genvar j = 0; j < 5; j++) begin : g_step
      logic signed [15:0] ck;
      efe_pkg::fix24_type acc_cur;
      efe_pkg::fix24_type s_cur;
      logic signed [47:0] prod_in;
      logic signed [47:0] sum;
      efe_pkg::fix24_type acc_in;

      if (4 - j < 4) begin : g_lo
         assign ck = coeff_lo[16*(4-j) +: 16];
      end else begin : g_hi
         assign ck = coeff_hi[15:0];
      end

      if (j == 0) begin : g_first
         assign acc_cur = acc0;
         assign s_cur   = s_ff;
      end else begin : g_next
         assign acc_cur = acc_ff[j];
         assign s_cur   = sa_ff[j-1];
      end

      assign prod_in = acc_cur * s_cur;
      assign sum     = (prod_ff[j] >>> 16) + ($signed({{32{ck[15]}}, ck}) <<< 6);
      assign acc_in  = efe_pkg::clamp24(sum);

      always_ff @(posedge clock) begin
         if (en) begin
            prod_ff[j]  <= prod_in;
            sm_ff[j]    <= s_cur;
            acc_ff[j+1] <= acc_in;
            sa_ff[j]    <= sm_ff[j];
         end
      end
   end

   assign poly_value = acc_ff[5];

endmodule

[src/efe_factor.sv]
// Enge factor 1/(1+exp(x)) in Q1.20: exp series, six squarings, bit divider.
// Depends on efe_pkg. Forty-seven register stages, all advanced by en.
module efe_factor (
   input  logic                clock,
   input  logic                en,
   input  efe_pkg::fix24_type  x,
   output efe_pkg::factor_type factor
);

   localparam logic [30:0] ONE30 = 31'h4000_0000;
   localparam logic [20:0] ONE20 = 21'h10_0000;

   logic [23:0] a_in;
   logic [27:0] r_ff;
   logic [1:0]  flag_ff [0:45];   // {sat, neg}

   logic [27:0] q1_ff  [0:5];
   logic [27:0] rm_ff  [0:5];
   logic [27:0] est_ff [0:5];
   logic [27:0] q2_ff  [0:5];
   logic [27:0] r2_ff  [0:5];
   logic [30:0] t_ff   [0:5];
   logic [27:0] r3_ff  [0:5];
   logic [30:0] sq_ff  [0:5];

   logic [31:0] den_in;
   logic [51:0] num_ff;
   logic [31:0] den_ff;
   logic [51:0] rem_ff [0:19];
   logic [31:0] dn_ff  [0:19];
   logic [19:0] quo_ff [0:19];

   efe_pkg::factor_type f_ff;
   efe_pkg::factor_type f_in;

   // Take magnitude, flag saturation, form r = a/64 in Q.30
   assign a_in = x[23] ? 24'(-x) : 24'(x);

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff       <= {a_in[19:0], 8'b0};
         flag_ff[0] <= {(a_in[23:20] != 4'd0), x[23]};
         for (int i = 1; i < 46; i++) begin
            flag_ff[i] <= flag_ff[i-1];
         end
      end
   end

   // Series steps t = 1 - (t*r)/k for k = 6 down to 1
   for (genvar j = 0; j < 6; j++) begin : g_series
      localparam int K = 6 - j;
      logic [30:0] t_cur;
      logic [27:0] r_cur;
      logic [58:0] p;
      logic [60:0] e;
      logic [30:0] ek;
      logic [30:0] rem;
      logic [27:0] quo;

      if (j == 0) begin : g_first
         assign t_cur = ONE30;
         assign r_cur = r_ff;
      end else begin : g_next
         assign t_cur = t_ff[j-1];
         assign r_cur = r3_ff[j-1];
      end

      assign p   = t_cur * r_cur;
      assign e   = q1_ff[j] * efe_pkg::RECIP_TAB[K];
      assign ek  = est_ff[j] * 31'(K);
      assign rem = {3'b0, q2_ff[j]} - ek;
      assign quo = (rem >= 31'(K)) ? est_ff[j] + 28'd1 : est_ff[j];

      always_ff @(posedge clock) begin
         if (en) begin
            q1_ff[j]  <= p[57:30];
            rm_ff[j]  <= r_cur;
            est_ff[j] <= e[59:32];
            q2_ff[j]  <= q1_ff[j];
            r2_ff[j]  <= rm_ff[j];
            t_ff[j]   <= ONE30 - {3'b0, quo};
            r3_ff[j]  <= r2_ff[j];
         end
      end
   end

   // Square six times with rounding
   for (genvar i = 0; i < 6; i++) begin : g_square
      logic [30:0] t_cur;
      logic [61:0] sq;

      if (i == 0) begin : g_first
         assign t_cur = t_ff[5];
      end else begin : g_next
         assign t_cur = sq_ff[i-1];
      end

      assign sq = t_cur * t_cur + 62'h2000_0000;

      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[i] <= sq[60:30];
         end
      end
   end

   // Set up rounded division y*2^20 / (2^30 + y)
   assign den_in = {1'b0, ONE30} + {1'b0, sq_ff[5]};

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff <= den_in;
         num_ff <= ({21'b0, sq_ff[5]} << 20) + {21'b0, den_in[31:1]};
      end
   end

   // Restoring divider, one quotient bit per stage
   for (genvar i = 0; i < 20; i++) begin : g_div
      localparam int B = 19 - i;
      logic [51:0] rem_cur;
      logic [31:0] den_cur;
      logic [19:0] quo_cur;
      logic [51:0] dsh;
      logic        take;

      if (i == 0) begin : g_first
         assign rem_cur = num_ff;
         assign den_cur = den_ff;
         assign quo_cur = 20'd0;
      end else begin : g_next
         assign rem_cur = rem_ff[i-1];
         assign den_cur = dn_ff[i-1];
         assign quo_cur = quo_ff[i-1];
      end

      assign dsh  = {20'b0, den_cur} << B;
      assign take = (rem_cur >= dsh);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= take ? rem_cur - dsh : rem_cur;
            dn_ff[i]  <= den_cur;
            quo_ff[i] <= quo_cur | (20'(take) << B);
         end
      end
   end

   // Select the factor by sign and saturation
   always_comb begin
      priority if (flag_ff[45][1]) begin
         f_in = flag_ff[45][0] ? ONE20 : 21'd0;
      end else if (flag_ff[45][0]) begin
         f_in = ONE20 - {1'b0, quo_ff[19]};
      end else begin
         f_in = {1'b0, quo_ff[19]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_ff <= f_in;
      end
   end

   assign factor = f_ff;

endmodule

[src/enge_product_field_eval.sv]
// Top level: register file, entry and exit sides, product stages, output buffer.
// Depends on efe_pkg, efe_side and efe_factor.
//
//  channel | ports                     | word
//  --------+---------------------------+------------------------------------
//  input   | req_tvalid/tready/tdata   | position, signed Q1.16
//  output  | rsp_tvalid/tready/tdata   | field_value, signed Q3.20
//  config  | csr_wen/csr_index/wdata   | one register per write, no read-back
//
// One word enters per cycle while the output buffer has room. Most pipeline stages
// are the series, squaring and divider stages of the factor unit.
// Reset is synchronous and resets valid bits, buffer state and config registers.
// A two-entry output buffer parts the sides: the pipeline advances whenever
// the buffer has room, so input is taken while one result waits.
module enge_product_field_eval (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [17:0] position
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [23:0] field_value
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic [63:0] entry_lo_ff, exit_lo_ff;
   logic [31:0] entry_hi_ff, exit_hi_ff;
   logic [23:0] amplitude_ff;
   logic [16:0] half_len_ff;
   logic [23:0] inv_aper_ff;

   logic                 en;
   logic                 vld_ff [0:efe_pkg::PIPE_LAT-1];
   logic signed [17:0]   z;
   efe_pkg::offset_type  d_entry, d_exit;
   efe_pkg::fix24_type   x_entry, x_exit;
   efe_pkg::factor_type  f_entry, f_exit;
   efe_pkg::factor_type  f_exit_ff;
   logic signed [45:0]   prod1_ff;
   logic signed [46:0]   prod2_ff;
   logic signed [24:0]   v1;
   logic signed [26:0]   v2;
   logic [23:0]          res;

   logic [23:0] buf_ff [0:1];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  cnt_ff;
   logic        push, pop;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_lo_ff  <= '0;
         entry_hi_ff  <= '0;
         exit_lo_ff   <= '0;
         exit_hi_ff   <= '0;
         amplitude_ff <= '0;
         half_len_ff  <= efe_pkg::HALF_LEN_RESET;
         inv_aper_ff  <= efe_pkg::INV_APER_RESET;
      end else if (csr_wen) begin
         unique case (efe_pkg::csr_index_type'(csr_index))
            efe_pkg::REG_ENTRY_LO:  entry_lo_ff  <= csr_wdata;
            efe_pkg::REG_ENTRY_HI:  entry_hi_ff  <= csr_wdata[31:0];
            efe_pkg::REG_EXIT_LO:   exit_lo_ff   <= csr_wdata;
            efe_pkg::REG_EXIT_HI:   exit_hi_ff   <= csr_wdata[31:0];
            efe_pkg::REG_AMPLITUDE: amplitude_ff <= csr_wdata[23:0];
            efe_pkg::REG_HALF_LEN:  half_len_ff  <= csr_wdata[16:0];
            efe_pkg::REG_INV_APER:  inv_aper_ff  <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // Advance the whole pipeline while the output buffer has room
   assign en         = (cnt_ff != 2'd2);
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < efe_pkg::PIPE_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < efe_pkg::PIPE_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // Offsets from the entry end and mirrored exit end
   assign z       = req_tdata[17:0];
   assign d_entry = 19'(z) - $signed({2'b0, half_len_ff});
   assign d_exit  = -19'(z) - $signed({2'b0, half_len_ff});

   efe_side u_side_entry (
      .clock        (clock),
      .en           (en),
      .offset       (d_entry),
      .inv_aperture (inv_aper_ff),
      .coeff_lo     (entry_lo_ff),
      .coeff_hi     (entry_hi_ff),
      .poly_value   (x_entry)
   );

   efe_side u_side_exit (
      .clock        (clock),
      .en           (en),
      .offset       (d_exit),
      .inv_aperture (inv_aper_ff),
      .coeff_lo     (exit_lo_ff),
      .coeff_hi     (exit_hi_ff),
      .poly_value   (x_exit)
   );

   efe_factor u_factor_entry (
      .clock  (clock),
      .en     (en),
      .x      (x_entry),
      .factor (f_entry)
   );

   efe_factor u_factor_exit (
      .clock  (clock),
      .en     (en),
      .x      (x_exit),
      .factor (f_exit)
   );

   // Scale amplitude by entry factor, then by exit factor delayed to match
   assign v1 = 25'(prod1_ff >>> 20);
   assign v2 = 27'(prod2_ff >>> 20);

   always_ff @(posedge clock) begin
      if (en) begin
         prod1_ff  <= $signed(amplitude_ff) * $signed({1'b0, f_entry});
         f_exit_ff <= f_exit;
         prod2_ff  <= v1 * $signed({1'b0, f_exit_ff});
      end
   end

   // Saturate to 24 signed bits
   always_comb begin
      priority if (v2 > 27'sd8388607) begin
         res = 24'h7F_FFFF;
      end else if (v2 < -27'sd8388608) begin
         res = 24'h80_0000;
      end else begin
         res = v2[23:0];
      end
   end

   // Two-entry output buffer
   assign push = en & vld_ff[efe_pkg::PIPE_LAT-1];
   assign pop  = rsp_tvalid & rsp_tready;

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = buf_ff[rd_ptr_ff];

endmodule

[tb/tb_enge_product_field_eval.sv]
// Testbench for enge_product_field_eval: drives positions, predicts each field value
// in fixed point and checks results in order. Depends on efe_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_enge_product_field_eval;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 80;
   localparam longint ONE30 = 64'sd1 << 30;
   localparam longint ONE20 = 64'sd1 << 20;
   localparam longint LIM23 = (64'sd1 << 23) - 1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_wen = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   // Shadow copy of the register file
   logic [63:0] entry_lo, exit_lo;
   logic [31:0] entry_hi, exit_hi;
   logic signed [23:0] amp;
   logic [16:0] half_len;
   logic [23:0] inv_aper;

   logic [23:0] field_queue [$];
   int  errors = 0;
   int  cycles = 0;
   bit  idle_on = 1'b1;

   enge_product_field_eval DUT (.*);

   always #5 clock = ~clock;

   // Stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic longint floor_div16(longint v);
      return v >>> 16;
   endfunction

   function automatic longint sat23(longint v);
      if (v > LIM23) return LIM23;
      if (v < -LIM23) return -LIM23;
      return v;
   endfunction

   function automatic longint coef_at(logic [63:0] lo, logic [31:0] hi, int k);
      logic signed [15:0] c;
      c = (k < 4) ? lo[k*16 +: 16] : hi[(k-4)*16 +: 16];
      return longint'(c);
   endfunction

   // 1/(1+exp(x)) in Q1.20
   function automatic longint enge_weight(longint x);
      longint a, r, t, g, den;
      a = (x < 0) ? -x : x;
      g = 0;
      if (a < ONE20) begin
         r = a * 256;
         t = ONE30;
         for (int k = 6; k >= 1; k--) t = ONE30 - ((t * r) >>> 30) / k;
         for (int k = 0; k < 6; k++) t = (t * t + (ONE30 >>> 1)) >>> 30;
         den = ONE30 + t;
         g = (t * ONE20 + den / 2) / den;
      end
      return (x >= 0) ? g : ONE20 - g;
   endfunction

   function automatic longint fringe_side(longint d, logic [63:0] lo, logic [31:0] hi);
      longint s, acc;
      s = sat23(floor_div16(d * longint'(inv_aper)));
      acc = coef_at(lo, hi, 5) * 64;
      for (int k = 4; k >= 0; k--)
         acc = sat23(floor_div16(acc * s) + coef_at(lo, hi, k) * 64);
      return enge_weight(acc);
   endfunction

   function automatic logic [23:0] predict_field(logic [17:0] pos);
      longint z, fi, fe, v;
      z = longint'($signed(pos));
      fi = fringe_side(z - longint'(half_len), entry_lo, entry_hi);
      fe = fringe_side(-z - longint'(half_len), exit_lo, exit_hi);
      v = (longint'(amp) * fi) >>> 20;
      v = (v * fe) >>> 20;
      if (v > LIM23) v = LIM23;
      if (v < -LIM23 - 1) v = -LIM23 - 1;
      return v[23:0];
   endfunction

   // Write one register while idle
   task automatic write_reg(efe_pkg::csr_index_type idx, logic [63:0] value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         efe_pkg::REG_ENTRY_LO:  entry_lo = value;
         efe_pkg::REG_ENTRY_HI:  entry_hi = value[31:0];
         efe_pkg::REG_EXIT_LO:   exit_lo = value;
         efe_pkg::REG_EXIT_HI:   exit_hi = value[31:0];
         efe_pkg::REG_AMPLITUDE: amp = value[23:0];
         efe_pkg::REG_HALF_LEN:  half_len = value[16:0];
         efe_pkg::REG_INV_APER:  inv_aper = value[23:0];
         default: ;
      endcase
   endtask

   // Send one position word, with optional idle burst first
   task automatic send_position(logic [17:0] pos);
      if (idle_on && $urandom_range(3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(13, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'($urandom_range(63)), pos};
      field_queue.push_back(predict_field(pos));
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (field_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_setting(logic [63:0] elo, logic [31:0] ehi, logic [63:0] xlo,
                               logic [31:0] xhi, logic [23:0] a, logic [16:0] h,
                               logic [23:0] ia);
      drain();
      write_reg(efe_pkg::REG_ENTRY_LO, elo);
      write_reg(efe_pkg::REG_ENTRY_HI, {32'hFFFF_FFFF, ehi});
      write_reg(efe_pkg::REG_EXIT_LO, xlo);
      write_reg(efe_pkg::REG_EXIT_HI, {32'h0, xhi});
      write_reg(efe_pkg::REG_AMPLITUDE, {40'hA5A5, a});
      write_reg(efe_pkg::REG_HALF_LEN, {47'h0, h});
      write_reg(efe_pkg::REG_INV_APER, {40'h0, ia});
   endtask

   task automatic test_directed();
      logic [17:0] edge_pos [7] = '{18'h20000, 18'h1FFFF, 18'h00000, 18'h3FFFF,
                                    18'h00001, 18'h0B333, 18'h34CCD};
      // Typical fringe: c0=0, c1=4 (steep), amplitude near full scale
      load_setting(64'h0000_0000_1000_0000, 32'h0, 64'h0000_0000_1000_0000, 32'h0,
                   24'h7FFFFF, 17'd45875, 24'd163840);
      foreach (edge_pos[i]) send_position(edge_pos[i]);
      // Saturating polynomial: extreme coefficients
      load_setting(64'h7FFF_8000_7FFF_8000, 32'h8000_7FFF, 64'h8000_7FFF_8000_7FFF,
                   32'h7FFF_8000, 24'h800000, 17'h1FFFF, 24'hFFFFFF);
      foreach (edge_pos[i]) send_position(edge_pos[i]);
      // Small argument region and zero aperture scale
      load_setting(64'h0000_0000_0100_FF00, 32'h0001_FFFF, 64'h0, 32'h0,
                   24'h400000, 17'd0, 24'd0);
      foreach (edge_pos[i]) send_position(edge_pos[i]);
      // Unknown register index is ignored
      drain();
      @(posedge clock);
      csr_wen <= 1'b1; csr_index <= 3'd7; csr_wdata <= '1;
      @(posedge clock);
      csr_wen <= 1'b0;
      send_position(18'h00000);
   endtask

   task automatic test_random(int phases, int per_phase);
      for (int p = 0; p < phases; p++) begin
         load_setting({$urandom, $urandom}, $urandom, {$urandom, $urandom}, $urandom,
                      24'($urandom), 17'($urandom),
                      (p % 2) ? 24'($urandom_range(400000)) : 24'($urandom));
         for (int i = 0; i < per_phase; i++) send_position(18'($urandom));
      end
   endtask

   task automatic test_moderate_fringe(int count);
      // Small coefficients keep the factors inside the smooth region
      load_setting({4'h0, 12'($urandom), 4'hF, 12'($urandom), 4'h0, 12'($urandom),
                    4'h0, 12'($urandom)}, {16'h0, 4'hF, 12'($urandom)},
                   {4'h0, 12'($urandom), 4'h0, 12'($urandom), 4'h0, 12'($urandom),
                    4'hF, 12'($urandom)}, 32'h0,
                   24'($urandom), 17'($urandom), 24'($urandom_range(300000)));
      for (int i = 0; i < count; i++) send_position(18'($urandom));
   endtask

   // Compare each result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (field_queue.size() == 0) begin
            $error("field_value: unexpected word %h", rsp_tdata);
            errors++;
         end else begin
            logic [23:0] want;
            want = field_queue.pop_front();
            if (rsp_tdata !== want) begin
               $error("field_value: expected %h, actual %h", want, rsp_tdata);
               errors++;
            end
         end
      end
   end

   // Receiver stalls in bursts, off at the end
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (idle_on && hold == 0 && $urandom_range(5) == 0) hold = $urandom_range(13, 1);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      entry_lo = '0; entry_hi = '0; exit_lo = '0; exit_hi = '0;
      amp = '0; half_len = efe_pkg::HALF_LEN_RESET; inv_aper = efe_pkg::INV_APER_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Reset values first
      send_position(18'h00000);
      send_position(18'h20000);
      test_directed();
      test_moderate_fringe(300);
      test_random(6, 200);
      test_moderate_fringe(200);
      idle_on = 1'b0;
      test_random(2, 150);
      drain();
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
